// ===== design/inode_double_hash_index_macros.svh =====
// assertion macros shared by the inode hash index rtl
`ifndef INODE_DOUBLE_HASH_INDEX_MACROS_SVH
`define INODE_DOUBLE_HASH_INDEX_MACROS_SVH

// property must hold at every clk edge outside reset
`define IDHI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true at a clk edge outside reset
`define IDHI_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== design/idhi_pkg.sv =====
// types and constants for the inode double hash index
`default_nettype none

package idhi_pkg;

  localparam int KEY_W      = 32;
  localparam int REF_W      = 32;
  localparam int STATUS_W   = 3;
  localparam int ACTION_W   = 2;
  localparam int SLOT_OUT_W = 12;
  localparam int SIZE_W     = 4;

  // slot word: valid, key, reference
  localparam int WORD_W = 1 + KEY_W + REF_W;

  localparam logic [31:0] START_MUL  = 32'hB28E457D;
  localparam logic [31:0] STRIDE_MUL = 32'h53B23891;

  localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = 4'd12;

  // register index from the byte address
  localparam logic REG_SIZE_LOG2 = 1'b0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_UNUSED = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_CLEARED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_HIT      = 3'd2,
    ST_MISS     = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_HASH_POS,
    S_HASH_STRIDE,
    S_PROBE,
    S_CHECK,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== design/idhi_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module idhi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/inode_double_hash_index.sv =====
// top level of the inode double hash index: control, hashing and probe sequencer
`default_nettype none
`include "inode_double_hash_index_macros.svh"

// open-addressing table of (inode, entry reference) pairs with double hashing.
// one beat in gives one beat out. the whole table lives in one ram of
// 2**SLOT_BITS words holding valid bit, key and reference; probing reads one
// word a cycle through that ram's single read port. an insert or lookup probes
// at most the active table size in slots, after which the result is table
// full. a clear action, and also reset, sweeps every ram word once to drop
// its valid bit, during which no input beat is taken; the sweep after reset
// gives no result beat. the unused action answers miss without probing. a
// finished result sits in the output register while the next input beat is
// accepted. the active size is min(size_log2, SLOT_BITS); write it only
// while the block is idle.

module inode_double_hash_index
  import idhi_pkg::*;
#(
  parameter int SLOT_BITS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // inode [31:0], entry_ref [63:32]
  input  wire logic [1:0]  in_tuser,   // action [1:0]
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [47:0] out_tdata,  // found_ref [31:0], slot_index [43:32], zero pad
  output logic      [2:0]  out_tuser,  // status [2:0]
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  localparam int DEPTH = 1 << SLOT_BITS;
  localparam int BW    = $clog2(SLOT_BITS + 1);

  // configuration register
  logic [SIZE_W-1:0] size_log2_r;

  // sequencer state
  state_t                 state_r,      state_nxt;
  action_t                action_r,     action_nxt;
  logic [KEY_W-1:0]       key_r,        key_nxt;
  logic [REF_W-1:0]       ref_r,        ref_nxt;
  logic [SLOT_BITS-1:0]   pos_r,        pos_nxt;
  logic [SLOT_BITS-1:0]   stride_r,     stride_nxt;
  logic [SLOT_BITS-1:0]   n_r,          n_nxt;
  logic [SLOT_BITS-1:0]   clr_cnt_r,    clr_cnt_nxt;
  logic                   clr_emit_r,   clr_emit_nxt;

  // finished result waiting for the output register
  status_t                res_status_r, res_status_nxt;
  logic [REF_W-1:0]       res_ref_r,    res_ref_nxt;
  logic [SLOT_OUT_W-1:0]  res_slot_r,   res_slot_nxt;

  // output register
  logic                   out_valid_r,  out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [REF_W-1:0]       out_ref_r,    out_ref_nxt;
  logic [SLOT_OUT_W-1:0]  out_slot_r,   out_slot_nxt;

  // ram port
  logic                   ram_we;
  logic [SLOT_BITS-1:0]   ram_waddr;
  logic [WORD_W-1:0]      ram_wdata;
  logic [SLOT_BITS-1:0]   ram_raddr;
  logic [WORD_W-1:0]      ram_rdata;

  // datapath helpers
  logic [BW-1:0]                      act_bits;
  logic [SLOT_BITS-1:0]               mask;
  logic [31:0]                        mul_const;
  logic [31:0]                        prod;
  logic [SLOT_BITS-1:0]               next_pos;
  logic [SLOT_BITS+SLOT_OUT_W-1:0]    slot_ext;
  logic [SLOT_OUT_W-1:0]              slot_out;
  logic                               rd_valid;
  logic [KEY_W-1:0]                   rd_key;
  logic [REF_W-1:0]                   rd_ref;
  logic                               cfg_wr;

  // ---------------------------------------------------------------------
  // configuration port, one register at byte address 0
  // ---------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_log2_r <= SIZE_LOG2_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_SIZE_LOG2)) begin
      size_log2_r <= cfg_pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_SIZE_LOG2) begin
      cfg_prdata = {{(32-SIZE_W){1'b0}}, size_log2_r};
    end
  end

  // active size saturates at the ram depth
  always_comb begin
    if (int'(size_log2_r) > SLOT_BITS) begin
      act_bits = BW'(SLOT_BITS);
    end else begin
      act_bits = BW'(size_log2_r);
    end
  end

  assign mask = ~({SLOT_BITS{1'b1}} << act_bits);

  // one shared multiplier: start constant first, stride constant next cycle
  assign mul_const = (state_r == S_HASH_POS) ? START_MUL : STRIDE_MUL;
  assign prod      = key_r * mul_const;

  assign next_pos = (pos_r + stride_r) & mask;

  // slot number reported modulo 2**12
  assign slot_ext = {{SLOT_OUT_W{1'b0}}, pos_r};
  assign slot_out = slot_ext[SLOT_OUT_W-1:0];

  // slot word fields
  assign rd_valid = ram_rdata[WORD_W-1];
  assign rd_key   = ram_rdata[REF_W +: KEY_W];
  assign rd_ref   = ram_rdata[REF_W-1:0];

  // ---------------------------------------------------------------------
  // slot table
  // ---------------------------------------------------------------------
  idhi_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    action_nxt     = action_r;
    key_nxt        = key_r;
    ref_nxt        = ref_r;
    pos_nxt        = pos_r;
    stride_nxt     = stride_r;
    n_nxt          = n_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_emit_nxt   = clr_emit_r;
    res_status_nxt = res_status_r;
    res_ref_nxt    = res_ref_r;
    res_slot_nxt   = res_slot_r;
    out_status_nxt = out_status_r;
    out_ref_nxt    = out_ref_r;
    out_slot_nxt   = out_slot_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = {1'b1, key_r, ref_r};
    ram_raddr      = pos_r;

    // result taken downstream
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          action_nxt = action_t'(in_tuser);
          key_nxt    = in_tdata[KEY_W-1:0];
          ref_nxt    = in_tdata[KEY_W +: REF_W];
          n_nxt      = '0;
          case (action_t'(in_tuser))
            ACT_CLEAR: begin
              clr_cnt_nxt  = '0;
              clr_emit_nxt = 1'b1;
              state_nxt    = S_CLEAR;
            end
            ACT_INSERT, ACT_LOOKUP: begin
              state_nxt = S_HASH_POS;
            end
            default: begin
              res_status_nxt = ST_MISS;
              res_ref_nxt    = '0;
              res_slot_nxt   = '0;
              state_nxt      = S_EMIT;
            end
          endcase
        end
      end

      S_CLEAR: begin
        // one word a cycle, valid bit dropped
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          if (clr_emit_r) begin
            res_status_nxt = ST_CLEARED;
            res_ref_nxt    = '0;
            res_slot_nxt   = '0;
            state_nxt      = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_HASH_POS: begin
        pos_nxt   = prod[SLOT_BITS-1:0] & mask;
        state_nxt = S_HASH_STRIDE;
      end

      S_HASH_STRIDE: begin
        stride_nxt = (prod[SLOT_BITS-1:0] & mask) | SLOT_BITS'(1);
        state_nxt  = S_PROBE;
      end

      S_PROBE: begin
        ram_raddr = pos_r;
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        // next probe address read ahead; used only if probing continues
        ram_raddr = next_pos;
        if (!rd_valid) begin
          if (action_r == ACT_INSERT) begin
            ram_we         = 1'b1;
            res_status_nxt = ST_INSERTED;
            res_slot_nxt   = slot_out;
          end else begin
            res_status_nxt = ST_MISS;
            res_slot_nxt   = '0;
          end
          res_ref_nxt = '0;
          state_nxt   = S_EMIT;
        end else if ((action_r == ACT_LOOKUP) && (rd_key == key_r)) begin
          res_status_nxt = ST_HIT;
          res_ref_nxt    = rd_ref;
          res_slot_nxt   = slot_out;
          state_nxt      = S_EMIT;
        end else if (n_r == mask) begin
          // every active slot visited
          res_status_nxt = ST_FULL;
          res_ref_nxt    = '0;
          res_slot_nxt   = '0;
          state_nxt      = S_EMIT;
        end else begin
          pos_nxt = next_pos;
          n_nxt   = n_r + 1'b1;
        end
      end

      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_ref_nxt    = res_ref_r;
          out_slot_nxt   = res_slot_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers; reset starts the clearing sweep with no result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      clr_emit_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_emit_r  <= clr_emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    action_r     <= action_nxt;
    key_r        <= key_nxt;
    ref_r        <= ref_nxt;
    pos_r        <= pos_nxt;
    stride_r     <= stride_nxt;
    n_r          <= n_nxt;
    res_status_r <= res_status_nxt;
    res_ref_r    <= res_ref_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_ref_r    <= out_ref_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  // ---------------------------------------------------------------------
  // ports
  // ---------------------------------------------------------------------
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(48-REF_W-SLOT_OUT_W){1'b0}}, out_slot_r, out_ref_r};
  assign out_tuser  = out_status_r;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  `IDHI_ASSERT(a_insert_ends_item, ram_we && (state_r == S_CHECK) |=> state_r == S_EMIT, "insert write did not end the item")
  `IDHI_ASSERT(a_sweep_runs, (state_r == S_CLEAR) && (clr_cnt_r != '1) |=> state_r == S_CLEAR, "clearing sweep stopped early")
  `IDHI_ASSERT(a_result_held, (state_r == S_EMIT) && out_valid_r && !out_tready |=> state_r == S_EMIT, "pending result overwrote output beat")
  `IDHI_ASSERT_NEVER(a_ref_only_on_hit, out_valid_r && (out_status_r != ST_HIT) && (out_ref_r != '0), "reference on a non-hit result")

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for the inode double hash index
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import idhi_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 9;
  localparam int SLOT_BITS    = 12;
  localparam int SLOT_COUNT   = 1 << SLOT_BITS;
  // a clear sweeps the whole ram, so long quiet stretches are normal
  localparam int STALL_LIMIT  = 60000;
  // cycles allowed for a stray beat to show up once nothing is pending
  localparam int DRAIN_TAIL   = 64;
  localparam int PHASE_BEATS  = 500;
  localparam int SEG_COUNT    = 12;

  // one result beat as the table answers it
  typedef struct {
    status_t     status;
    logic [31:0] found_ref;
    logic [11:0] slot_index;
  } answer_t;

  // one line of the directed table: either an input beat or a size_log2 write
  typedef struct {
    bit          is_cfg;
    action_t     action;
    logic [31:0] inode;      // new size_log2 on a register line
    logic [31:0] entry_ref;
    bit          typed;      // answer below is fixed, not predicted
    answer_t     want;
  } script_row_t;

  // dut ports, every input known from time zero
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata    = '0;   // inode [31:0], entry_ref [63:32]
  logic [1:0]  in_tuser    = '0;   // action [1:0]
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [47:0] out_tdata;          // found_ref [31:0], slot_index [43:32], zero pad
  logic [2:0]  out_tuser;          // status [2:0]
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // shadow copy of the table and its size register
  bit          tbl_used  [SLOT_COUNT];
  logic [31:0] tbl_inode [SLOT_COUNT];
  logic [31:0] tbl_eref  [SLOT_COUNT];
  logic [3:0]  size_reg = SIZE_LOG2_RESET;

  answer_t     pending_answers [$];   // answers owed by the dut, oldest first
  logic [31:0] live_inodes [$];       // recently inserted keys, reused for hits and duplicates
  int          send_gap_pct   = 0;
  int          recv_stall_pct = 0;
  int          error_count    = 0;
  int          quiet_cycles   = 0;
  int          seg_sizes [SEG_COUNT] = '{0, 3, 12, 1, 5, 15, 2, 7, 13, 4, 8, 6};

  inode_double_hash_index #(
    .SLOT_BITS(SLOT_BITS)
  ) dut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // works out the answer to one beat and applies its effect on the shadow table
  function automatic answer_t probe_table(action_t act, logic [31:0] inode,
                                          logic [31:0] eref);
    answer_t     ans;
    int unsigned bits;
    logic [31:0] mask;
    logic [31:0] pos;
    logic [31:0] stride;
    logic [31:0] slot;
    ans.status     = ST_MISS;
    ans.found_ref  = '0;
    ans.slot_index = '0;
    // settings above the ram size saturate
    bits   = (size_reg > SLOT_BITS) ? SLOT_BITS : size_reg;
    mask   = (32'd1 << bits) - 32'd1;
    pos    = inode * START_MUL;
    stride = ((inode * STRIDE_MUL) & mask) | 32'd1;
    case (act)
      ACT_CLEAR: begin
        foreach (tbl_used[i]) tbl_used[i] = 1'b0;
        ans.status = ST_CLEARED;
      end
      ACT_INSERT, ACT_LOOKUP: begin
        // odd stride, so 2**bits probes visit every active slot once
        ans.status = ST_FULL;
        for (int n = 0; n < (1 << bits); n++) begin
          slot = pos & mask;
          if (!tbl_used[slot]) begin
            if (act == ACT_INSERT) begin
              tbl_used[slot]  = 1'b1;
              tbl_inode[slot] = inode;
              tbl_eref[slot]  = eref;
              ans.status      = ST_INSERTED;
              ans.slot_index  = slot[11:0];
            end else begin
              ans.status = ST_MISS;
            end
            break;
          end
          if (act == ACT_LOOKUP && tbl_inode[slot] == inode) begin
            ans.status     = ST_HIT;
            ans.found_ref  = tbl_eref[slot];
            ans.slot_index = slot[11:0];
            break;
          end
          pos = pos + stride;
        end
      end
      default: begin
        // unused action: miss, nothing touched
        ans.status = ST_MISS;
      end
    endcase
    return ans;
  endfunction

  function automatic script_row_t script_row(bit is_cfg, action_t act, logic [31:0] inode,
                                             logic [31:0] eref, bit typed = 1'b0,
                                             status_t st = ST_MISS,
                                             logic [31:0] fref = '0,
                                             logic [11:0] slot = '0);
    script_row_t r;
    r.is_cfg          = is_cfg;
    r.action          = act;
    r.inode           = inode;
    r.entry_ref       = eref;
    r.typed           = typed;
    r.want.status     = st;
    r.want.found_ref  = fref;
    r.want.slot_index = slot;
    return r;
  endfunction

  // presents one input beat, entered and left at a falling edge
  task automatic send_beat(action_t act, logic [31:0] inode, logic [31:0] eref,
                           bit typed, answer_t typed_ans);
    answer_t predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {eref, inode};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    predicted = probe_table(act, inode, eref);
    pending_answers.push_back(typed ? typed_ans : predicted);
    @(negedge clk);
  endtask

  // hold the input back until every owed answer has come out
  task automatic drain_answers();
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  // apb write of size_log2, then read it back
  task automatic write_size_log2(logic [3:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {REG_SIZE_LOG2, 2'b00};
    cfg_pwdata  <= {28'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    size_reg = value;
    @(negedge clk);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {28'd0, value}) begin
      $error("size_log2 read back: expected %0d, got %0d", value, cfg_prdata);
      error_count++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // result checker: each beat against the oldest owed answer
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        $error("result beat with nothing pending: status %0d, found_ref %0h",
               out_tuser, out_tdata[31:0]);
        error_count++;
      end else begin
        want = pending_answers.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          error_count++;
        end
        if (out_tdata[31:0] !== want.found_ref) begin
          $error("found_ref: expected %0h, got %0h", want.found_ref, out_tdata[31:0]);
          error_count++;
        end
        if (out_tdata[43:32] !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, out_tdata[43:32]);
          error_count++;
        end
      end
    end
  end

  // watchdog: too long without any beat or register access means a hang
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    script_row_t script [$];
    answer_t     no_ans;
    action_t     act;
    logic [31:0] inode;
    int          pick;
    int          seg;
    int          beats;
    int          seg_beats;

    no_ans.status     = ST_MISS;
    no_ans.found_ref  = '0;
    no_ans.slot_index = '0;

    // directed lines; the first ones run at the reset size of 4096 slots
    // empty table after reset
    script.push_back(script_row(0, ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1, ST_MISS));
    // unused action answers miss with zero fields
    script.push_back(script_row(0, ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_MISS));
    // key zero hashes to slot zero
    script.push_back(script_row(0, ACT_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1,
                                ST_INSERTED, 32'h0, 12'd0));
    script.push_back(script_row(0, ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1,
                                ST_HIT, 32'hFFFF_FFFF, 12'd0));
    script.push_back(script_row(0, ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0000));
    // duplicate key lands in a further slot, lookup still finds the first
    script.push_back(script_row(0, ACT_INSERT, 32'hFFFF_FFFF, 32'h1234_5678));
    script.push_back(script_row(0, ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000));
    script.push_back(script_row(0, ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_CLEARED));
    script.push_back(script_row(0, ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1, ST_MISS));
    // single slot table: second insert and a non-matching lookup see it full
    script.push_back(script_row(1, ACT_CLEAR, 32'd0, 32'h0));
    script.push_back(script_row(0, ACT_INSERT, 32'h0000_1234, 32'hA5A5_5A5A, 1,
                                ST_INSERTED, 32'h0, 12'd0));
    script.push_back(script_row(0, ACT_INSERT, 32'h0000_5678, 32'h0000_0001, 1, ST_FULL));
    script.push_back(script_row(0, ACT_LOOKUP, 32'h0000_5678, 32'h0000_0000, 1, ST_FULL));
    script.push_back(script_row(0, ACT_LOOKUP, 32'h0000_1234, 32'h0000_0000, 1,
                                ST_HIT, 32'hA5A5_5A5A, 12'd0));
    // oversized setting saturates; slots written under the old size survive
    script.push_back(script_row(1, ACT_CLEAR, 32'd15, 32'h0));
    script.push_back(script_row(0, ACT_LOOKUP, 32'h0000_1234, 32'h0000_0000));
    script.push_back(script_row(0, ACT_INSERT, 32'h0000_0000, 32'h8000_0001));
    script.push_back(script_row(0, ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000));
    // two slot table filled up
    script.push_back(script_row(1, ACT_CLEAR, 32'd1, 32'h0));
    script.push_back(script_row(0, ACT_CLEAR, 32'h0000_0000, 32'h0000_0000, 1, ST_CLEARED));
    script.push_back(script_row(0, ACT_INSERT, 32'h0000_0007, 32'h0000_0070));
    script.push_back(script_row(0, ACT_INSERT, 32'h0000_0007, 32'h0000_0071));
    script.push_back(script_row(0, ACT_INSERT, 32'h0000_0009, 32'h0000_0090, 1, ST_FULL));
    script.push_back(script_row(0, ACT_LOOKUP, 32'h0000_0009, 32'h0000_0000, 1, ST_FULL));
    script.push_back(script_row(0, ACT_LOOKUP, 32'h0000_0007, 32'h0000_0000));

    send_gap_pct   = 7;
    recv_stall_pct = 53;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // the post-reset sweep simply holds in_tready low for a while
    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        drain_answers();
        write_size_log2(script[i].inode[3:0]);
      end else begin
        send_beat(script[i].action, script[i].inode, script[i].entry_ref,
                  script[i].typed, script[i].want);
      end
    end

    // random traffic: receiver-heavy stalls, then sender-heavy gaps, then flat out
    seg = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_gap_pct   = (phase == 0) ? 7 : (phase == 1) ? 53 : 0;
      recv_stall_pct = (phase == 0) ? 53 : (phase == 1) ? 7 : 0;
      beats = 0;
      while (beats < PHASE_BEATS) begin
        // size changes only with the block quiet
        drain_answers();
        write_size_log2(seg_sizes[seg % SEG_COUNT]);
        seg_beats = (seg_sizes[seg % SEG_COUNT] >= SLOT_BITS) ? 30 : 50;
        repeat (seg_beats) begin
          pick  = $urandom_range(99);
          inode = $urandom;
          if (pick < 2) begin
            act = ACT_CLEAR;
            live_inodes.delete();
          end else if (pick < 5) begin
            act = ACT_UNUSED;
          end else if (pick < 45) begin
            act = ACT_INSERT;
            if (live_inodes.size() != 0 && $urandom_range(99) < 30) begin
              // duplicate of a key already in
              inode = live_inodes[$urandom_range(live_inodes.size() - 1)];
            end else begin
              live_inodes.push_back(inode);
              if (live_inodes.size() > 64) void'(live_inodes.pop_front());
            end
          end else begin
            act = ACT_LOOKUP;
            // mostly keys that should hit, the rest fresh keys that should miss
            if (live_inodes.size() != 0 && pick < 85) begin
              inode = live_inodes[$urandom_range(live_inodes.size() - 1)];
            end
          end
          send_beat(act, inode, $urandom, 1'b0, no_ans);
        end
        beats += seg_beats;
        seg++;
      end
    end

    drain_answers();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
